// ----- sv/swm_pkg.sv -----
`timescale 1ns / 1ps

package swm_pkg;

	// width of the window_size register
	localparam int unsigned CFG_WIDTH = 9;

	// per-cycle command broadcast to every cell of the row
	typedef struct packed {
		logic load;   // an item is taken: drop smaller tail entries, append
		logic pop;    // shift the row one place toward the front
		logic clear;  // restart: treat every entry as empty
	} cell_ctrl_t;

endpackage

// ----- sv/swm_cell.sv -----
`timescale 1ns / 1ps

module swm_cell #(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned POS_WIDTH  = 9,
	parameter int unsigned WIN_WIDTH  = 9,
	parameter int unsigned POS_MOD    = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swm_pkg::cell_ctrl_t   ctrl,
	input  logic [DATA_WIDTH-1:0] sample,
	input  logic [POS_WIDTH-1:0]  item_pos,
	input  logic [POS_WIDTH-1:0]  pos_cnt,
	input  logic [WIN_WIDTH-1:0]  win,
	input  logic                  nxt_valid,
	input  logic [DATA_WIDTH-1:0] nxt_value,
	input  logic [POS_WIDTH-1:0]  nxt_pos,
	input  logic                  prv_kept,
	output logic                  valid,
	output logic [DATA_WIDTH-1:0] value,
	output logic [POS_WIDTH-1:0]  pos,
	output logic                  kept,
	output logic                  expired,
	output logic [DATA_WIDTH-1:0] value_next
);

	logic                  valid_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [POS_WIDTH-1:0]  pos_q;
	logic                  view_valid;
	logic [DATA_WIDTH-1:0] view_value;
	logic [POS_WIDTH-1:0]  view_pos;
	logic                  take_new;
	logic                  valid_d;
	logic [POS_WIDTH-1:0]  pos_d;
	logic [POS_WIDTH:0]    age;

	// age of the held entry against the current stream position
	always_comb begin
		if (pos_cnt >= pos_q) begin
			age = {1'b0, pos_cnt} - {1'b0, pos_q};
		end else begin
			age = {1'b0, pos_cnt} + (POS_WIDTH+1)'(POS_MOD) - {1'b0, pos_q};
		end
	end

	assign expired = valid_q && (age >= (POS_WIDTH+1)'(win));

	// entry as seen after an optional front pop
	always_comb begin
		view_valid = ctrl.pop ? nxt_valid : valid_q;
		view_value = ctrl.pop ? nxt_value : value_q;
		view_pos   = ctrl.pop ? nxt_pos : pos_q;
		if (ctrl.clear) begin
			view_valid = 1'b0;
		end
	end

	// keep ties, drop strictly smaller entries
	assign kept     = view_valid && !($signed(view_value) < $signed(sample));
	assign take_new = !kept && prv_kept;

	always_comb begin
		if (ctrl.load) begin
			valid_d    = kept || take_new;
			value_next = kept ? view_value : sample;
			pos_d      = kept ? view_pos : item_pos;
		end else begin
			valid_d    = view_valid;
			value_next = view_value;
			pos_d      = view_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.load || ctrl.pop) begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load || ctrl.pop) begin
			value_q <= value_next;
			pos_q   <= pos_d;
		end
	end

	assign valid = valid_q;
	assign value = value_q;
	assign pos   = pos_q;

endmodule

// ----- sv/sliding_window_maximum_unit.sv -----
`timescale 1ns / 1ps

// Running maximum over the last window_size signed samples of a stream. Each
// item carries a sample in s_tdata and a restart flag in s_tuser; restart
// clears the window so that the item opens a new sequence. Once window_size
// samples of the sequence have been taken, every item yields one result, the
// maximum of the last window_size samples, on the m_ side; shorter sequences
// yield nothing. window_size 0 acts as 1, values above MAX_WINDOW act as
// MAX_WINDOW. Candidates live in a row of MAX_WINDOW cells holding a
// non-increasing queue, front at cell 0. Rate: one item per clock while
// results are taken and no expired candidates are being cleared. After
// window_size is lowered, the first item waits while expired candidates past
// the first are cleared; the row shifts one place toward the front per cycle.
module sliding_window_maximum_unit #(
	parameter int unsigned MAX_WINDOW = 256,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config: window_size
	input  logic                                 cfg_we,
	input  logic [swm_pkg::CFG_WIDTH-1:0]        cfg_wdata,
	// input items
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]      s_tdata,   // sample
	input  logic                                 s_tuser,   // restart
	// result items
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [((DATA_WIDTH+7)/8)*8-1:0]      m_tdata    // window_max
);

	localparam int unsigned TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int unsigned POS_MOD = 2 * MAX_WINDOW;
	localparam int unsigned POS_W   = (POS_MOD > 2) ? $clog2(POS_MOD) : 1;
	localparam int unsigned WIN_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW + 1) : 1;

	logic [swm_pkg::CFG_WIDTH-1:0] cfg_q;
	logic [WIN_W-1:0]              win;
	logic [POS_W-1:0]              pos_cnt_q;
	logic [POS_W-1:0]              item_pos;
	logic [WIN_W-1:0]              seen_q;
	logic [WIN_W-1:0]              seen_base;
	logic [WIN_W-1:0]              seen_d;
	logic                          emit;
	logic                          accept;
	logic                          drain;
	logic                          out_free;
	logic [DATA_WIDTH-1:0]         sample;
	swm_pkg::cell_ctrl_t           ctrl;
	logic                          m_tvalid_q;
	logic [DATA_WIDTH-1:0]         m_data_q;

	logic [MAX_WINDOW-1:0]         cell_valid;
	logic [MAX_WINDOW-1:0]         cell_kept;
	logic [MAX_WINDOW-1:0]         cell_expired;
	logic [DATA_WIDTH-1:0]         cell_value [MAX_WINDOW];
	logic [DATA_WIDTH-1:0]         cell_next  [MAX_WINDOW];
	logic [POS_W-1:0]              cell_pos   [MAX_WINDOW];

	assign sample = s_tdata[DATA_WIDTH-1:0];

	// window_size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= swm_pkg::CFG_WIDTH'(1);
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// clamp the programmed window into 1 .. MAX_WINDOW
	always_comb begin
		if (cfg_q == '0) begin
			win = WIN_W'(1);
		end else if (32'(cfg_q) > 32'(MAX_WINDOW)) begin
			win = WIN_W'(MAX_WINDOW);
		end else begin
			win = WIN_W'(cfg_q);
		end
	end

	// A second expired candidate only shows up after the window shrank; clear
	// those one per cycle while an item waits, so that at most the front one
	// is left to drop when the item is taken.
	generate
		if (MAX_WINDOW > 1) begin : g_drain
			assign drain = cell_expired[1];
		end else begin : g_no_drain
			assign drain = 1'b0;
		end
	endgenerate

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = !drain && out_free;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		ctrl.load  = accept;
		ctrl.clear = accept && s_tuser;
		ctrl.pop   = (s_tvalid && drain) || (accept && !s_tuser && cell_expired[0]);
	end

	assign item_pos = s_tuser ? '0 : pos_cnt_q;

	// sample count of the sequence, held at the window once reached
	always_comb begin
		seen_base = s_tuser ? '0 : seen_q;
		if (seen_base >= win) begin
			seen_d = win;
		end else begin
			seen_d = seen_base + WIN_W'(1);
		end
	end

	assign emit = seen_d >= win;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_cnt_q <= '0;
			seen_q    <= '0;
		end else if (accept) begin
			seen_q <= seen_d;
			if (item_pos == POS_W'(POS_MOD - 1)) begin
				pos_cnt_q <= '0;
			end else begin
				pos_cnt_q <= item_pos + POS_W'(1);
			end
		end
	end

	// row of queue cells; each sees only its two neighbors
	generate
		for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
			logic                  nxt_valid;
			logic [DATA_WIDTH-1:0] nxt_value;
			logic [POS_W-1:0]      nxt_pos;
			logic                  prv_kept;

			if (i == MAX_WINDOW - 1) begin : g_tail
				assign nxt_valid = 1'b0;
				assign nxt_value = '0;
				assign nxt_pos   = '0;
			end else begin : g_link
				assign nxt_valid = cell_valid[i+1];
				assign nxt_value = cell_value[i+1];
				assign nxt_pos   = cell_pos[i+1];
			end

			if (i == 0) begin : g_head
				assign prv_kept = 1'b1;
			end else begin : g_back
				assign prv_kept = cell_kept[i-1];
			end

			swm_cell #(
				.DATA_WIDTH (DATA_WIDTH),
				.POS_WIDTH  (POS_W),
				.WIN_WIDTH  (WIN_W),
				.POS_MOD    (POS_MOD)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.sample     (sample),
				.item_pos   (item_pos),
				.pos_cnt    (pos_cnt_q),
				.win        (win),
				.nxt_valid  (nxt_valid),
				.nxt_value  (nxt_value),
				.nxt_pos    (nxt_pos),
				.prv_kept   (prv_kept),
				.valid      (cell_valid[i]),
				.value      (cell_value[i]),
				.pos        (cell_pos[i]),
				.kept       (cell_kept[i]),
				.expired    (cell_expired[i]),
				.value_next (cell_next[i])
			);
		end
	endgenerate

	// result register: the new front of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept && emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			m_data_q <= cell_next[0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_W'(m_data_q);

	// occupied cells always form an unbroken run from the front
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, cell_valid} + (MAX_WINDOW+1)'(1)))
		else $error("queue cells not front-aligned");

	// a taken item never meets a pending multi-entry drop
	a_no_drain_accept: assert property (@(posedge clk) disable iff (!arst_n)
		drain |-> !accept)
		else $error("item taken while expired entries remain");

	// after an item the front holds a value no smaller than that sample
	a_front_dominates: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cell_valid[0] &&
			!($signed(cell_value[0]) < $signed($past(sample))))
		else $error("queue front below the newest sample");

	// a result is presented right after the item that produced it
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit |=> m_tvalid)
		else $error("result missing after item");

endmodule
